// ===== design/ddo_pkg.sv =====
// ----------------------------------------------------------------------------
// ddo_pkg - shared types and constants for the wheel odometry block
// Item layouts, register resets, fixed-point constants, arctangent table and
// the request format of the shared serial multiplier.
// ----------------------------------------------------------------------------
`default_nettype none
package ddo_pkg;

  // Register reset values
  localparam logic [31:0] MPT_RESET = 32'd894785;   // 1/4800 m, Q0.32
  localparam logic [23:0] ITW_RESET = 24'd819200;   // 1/0.08 per m, Q8.16

  // Scale from radians to binary angle: round(2^32 / (2 pi))
  localparam logic [31:0] TURN_INV_2PI = 32'd683565276;
  // CORDIC start value, Q2.30, pre-divided by the rotation gain
  localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;
  localparam int CORDIC_STEPS_DEF = 24;

  // Serial multiplier widths: multiplicand and accumulator
  localparam int MUL_AW   = 57;
  localparam int MUL_ACCW = MUL_AW + 1;

  // Floor-rounded arctangent of 2^-i as binary angle
  localparam logic [31:0] ATAN_TBL [32] = '{
    32'd536870912, 32'd316933405, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354465,  32'd10679838,  32'd5340245,   32'd2670163,  32'd1335086,
    32'd667544,    32'd333772,    32'd166886,    32'd83443,    32'd41721,
    32'd20860,     32'd10430,     32'd5215,      32'd2607,     32'd1303,
    32'd651,       32'd325,       32'd162,       32'd81,       32'd40,
    32'd20,        32'd10,        32'd5,         32'd2,        32'd1,
    32'd0,         32'd0
  };

  typedef struct packed {
    logic signed [31:0] left_count;
    logic signed [31:0] right_count;
    logic [62:0]        stamp_in;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] heading;
    logic [62:0]        stamp_out;
  } out_item_t;

  // One multiply job: a times b, b taken over last_bit+1 bits
  typedef struct packed {
    logic signed [MUL_AW-1:0] a;
    logic [31:0]              b;
    logic [4:0]               last_bit;
    logic                     b_signed;
  } mul_req_t;

endpackage
`default_nettype wire

// ===== design/ddo_mul.sv =====
// ----------------------------------------------------------------------------
// ddo_mul - bit-serial shift-add multiplier
// Takes one multiplier bit per cycle, least significant first. The high part
// of the product builds up in acc, the low bits shift out into low.
// ----------------------------------------------------------------------------
`default_nettype none
module ddo_mul (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  go,
  input  ddo_pkg::mul_req_t                     req,
  output logic                                  done,
  output logic signed [ddo_pkg::MUL_ACCW-1:0]   acc,
  output logic [31:0]                           low
);
  import ddo_pkg::*;

  logic                      busy_r;
  logic                      done_r;
  logic [4:0]                cnt_r;
  logic [4:0]                last_r;
  logic                      bsgn_r;
  logic signed [MUL_AW-1:0]  a_r;
  logic [31:0]               b_r;
  logic signed [MUL_ACCW-1:0] acc_r;
  logic [31:0]               low_r;

  logic                      is_last;
  logic                      neg;
  logic signed [MUL_AW-1:0]  addend;
  logic signed [MUL_ACCW:0]  sum;

  // One partial product; the sign bit of a signed multiplier weighs negative
  always_comb begin
    is_last = (cnt_r == last_r);
    neg     = is_last && bsgn_r && b_r[0];
    addend  = b_r[0] ? a_r : '0;
    if (neg) begin
      sum = {acc_r[MUL_ACCW-1], acc_r} - {{2{addend[MUL_AW-1]}}, addend};
    end else begin
      sum = {acc_r[MUL_ACCW-1], acc_r} + {{2{addend[MUL_AW-1]}}, addend};
    end
  end

  // Control: start, count, finish
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (go) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 5'd1;
        if (is_last) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Datapath: load operands, then shift one bit per cycle
  always_ff @(posedge clk) begin
    if (go) begin
      a_r    <= req.a;
      b_r    <= req.b;
      last_r <= req.last_bit;
      bsgn_r <= req.b_signed;
      acc_r  <= '0;
      low_r  <= '0;
    end else if (busy_r) begin
      acc_r <= sum[MUL_ACCW:1];
      low_r <= {sum[0], low_r[31:1]};
      b_r   <= {1'b0, b_r[31:1]};
    end
  end

  assign done = done_r;
  assign acc  = acc_r;
  assign low  = low_r;

endmodule
`default_nettype wire

// ===== design/ddo_cordic.sv =====
// ----------------------------------------------------------------------------
// ddo_cordic - iterative CORDIC sine and cosine
// Rotates a pre-scaled unit vector to a binary angle, one micro-rotation per
// cycle; angles beyond a quarter turn are folded by a half turn first.
// ----------------------------------------------------------------------------
`default_nettype none
module ddo_cordic #(
  parameter int CORDIC_STEPS = ddo_pkg::CORDIC_STEPS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               go,
  input  logic [31:0]        angle,
  output logic               done,
  output logic signed [31:0] cos_out,
  output logic signed [31:0] sin_out
);
  import ddo_pkg::*;

  localparam int NSTEP = (CORDIC_STEPS > 32) ? 32 : CORDIC_STEPS;
  localparam logic [4:0] LAST_IT = 5'(NSTEP - 1);

  logic               busy_r;
  logic               done_r;
  logic [4:0]         it_r;
  logic               flip_r;
  logic signed [33:0] x_r;
  logic signed [33:0] y_r;
  logic signed [33:0] z_r;

  logic               fold;
  logic [31:0]        start_ang;
  logic signed [33:0] xs;
  logic signed [33:0] ys;
  logic signed [33:0] t;
  logic signed [33:0] x_neg;
  logic signed [33:0] y_neg;

  // Fold the start angle into the right half plane
  always_comb begin
    fold      = ($signed(angle) > 32'sd1073741824) || ($signed(angle) < -32'sd1073741824);
    start_ang = fold ? (angle + 32'h8000_0000) : angle;
    xs        = x_r >>> it_r;
    ys        = y_r >>> it_r;
    t         = $signed({2'b00, ATAN_TBL[it_r]});
    x_neg     = -x_r;
    y_neg     = -y_r;
  end

  // Control: start, iterate, finish
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      it_r   <= '0;
    end else begin
      done_r <= 1'b0;
      if (go) begin
        busy_r <= 1'b1;
        it_r   <= '0;
      end else if (busy_r) begin
        it_r <= it_r + 5'd1;
        if (it_r == LAST_IT) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Micro-rotation toward zero residual angle
  always_ff @(posedge clk) begin
    if (go) begin
      flip_r <= fold;
      x_r    <= CORDIC_GAIN;
      y_r    <= '0;
      z_r    <= {{2{start_ang[31]}}, start_ang};
    end else if (busy_r) begin
      if (z_r >= 0) begin
        x_r <= x_r - ys;
        y_r <= y_r + xs;
        z_r <= z_r - t;
      end else begin
        x_r <= x_r + ys;
        y_r <= y_r - xs;
        z_r <= z_r + t;
      end
    end
  end

  assign done    = done_r;
  assign cos_out = flip_r ? x_neg[31:0] : x_r[31:0];
  assign sin_out = flip_r ? y_neg[31:0] : y_r[31:0];

endmodule
`default_nettype wire

// ===== design/differential_drive_odometry.sv =====
// ----------------------------------------------------------------------------
// differential_drive_odometry - wheel encoder odometry, pose integrator
// Turns cumulative left/right encoder counts into an x, y, heading pose.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : valid/ready channel of encoder samples (counts and time stamp).
//   out_* : valid/ready channel of poses, one per sample after the first.
//   APB   : metres_per_tick at 0x0, inverse_track_width at 0x4; write only
//           while idle. pready is tied high, reads return the register.
// Sequencing:
//   One sample at a time. Each sample runs six bit-serial multiplies of 24
//   to 32 bits on one shared shift-add unit, with the CORDIC rotations
//   between them. The first sample after reset only latches the counts.
// Reset clears the pose, the latched counts and the registers to defaults.
// The pose sits in an output register; a stalled receiver holds it there,
// and the next sample is taken meanwhile, blocking only at its own emit.
// ----------------------------------------------------------------------------
`default_nettype none
module differential_drive_odometry #(
  parameter int CORDIC_STEPS = ddo_pkg::CORDIC_STEPS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  ddo_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output ddo_pkg::out_item_t out_data,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  import ddo_pkg::*;

  typedef enum logic [10:0] {
    S_IDLE  = 11'b000_0000_0001,
    S_LOAD  = 11'b000_0000_0010,
    S_MUL_L = 11'b000_0000_0100,
    S_MUL_R = 11'b000_0000_1000,
    S_SUMS  = 11'b000_0001_0000,
    S_MUL_D = 11'b000_0010_0000,
    S_MUL_H = 11'b000_0100_0000,
    S_CORD  = 11'b000_1000_0000,
    S_MUL_X = 11'b001_0000_0000,
    S_MUL_Y = 11'b010_0000_0000,
    S_EMIT  = 11'b100_0000_0000
  } state_t;

  localparam logic REG_MPT = 1'b0;
  localparam logic REG_ITW = 1'b1;

  function automatic logic signed [31:0] sat32(input logic signed [48:0] v);
    if (v > 49'sd2147483647) begin
      return 32'sh7fff_ffff;
    end else if (v < -49'sd2147483648) begin
      return 32'sh8000_0000;
    end else begin
      return v[31:0];
    end
  endfunction

  state_t state_r, state_nxt;

  logic [31:0]        mpt_r;
  logic [23:0]        itw_r;
  logic               seen_r;
  logic [31:0]        last_l_r;
  logic [31:0]        last_r_r;
  logic signed [31:0] pose_x_r;
  logic signed [31:0] pose_y_r;
  logic [31:0]        pose_h_r;

  logic [31:0]        smp_l_r;
  logic [31:0]        smp_r_r;
  logic [62:0]        stamp_r;
  logic signed [31:0] tick_l_r;
  logic signed [31:0] tick_r_r;
  logic signed [47:0] dl_r;
  logic signed [47:0] dr_r;
  logic signed [31:0] trav_r;
  logic signed [31:0] diff_r;
  logic signed [55:0] r32_r;
  logic [31:0]        turn_r;
  logic [31:0]        mid_r;
  logic signed [31:0] cs_r;
  logic signed [31:0] sn_r;

  logic               mul_go_r;
  logic               cor_go_r;
  logic               out_valid_r;
  out_item_t          out_data_r;

  mul_req_t                   mreq;
  logic                       mul_done;
  logic signed [MUL_ACCW-1:0] mul_acc;
  logic [31:0]                mul_low;
  logic                       cor_done;
  logic signed [31:0]         cor_cos;
  logic signed [31:0]         cor_sin;

  logic                       in_xfer;
  logic                       cfg_wr;
  logic                       out_free;
  logic signed [48:0]         lr_sum;
  logic signed [48:0]         lr_dif;
  logic signed [31:0]         dx;
  logic signed [31:0]         dy;

  assign in_xfer  = in_valid && in_ready;
  assign cfg_wr   = psel && penable && pwrite && pready;
  assign out_free = !out_valid_r || out_ready;

  // Operand selection for the shared multiplier
  always_comb begin
    mreq = '{a: '0, b: '0, last_bit: 5'd31, b_signed: 1'b0};
    unique case (state_r)
      S_MUL_L: mreq = '{a: {{25{tick_l_r[31]}}, tick_l_r}, b: mpt_r,
                        last_bit: 5'd31, b_signed: 1'b0};
      S_MUL_R: mreq = '{a: {{25{tick_r_r[31]}}, tick_r_r}, b: mpt_r,
                        last_bit: 5'd31, b_signed: 1'b0};
      S_MUL_D: mreq = '{a: {{25{diff_r[31]}}, diff_r}, b: {8'd0, itw_r},
                        last_bit: 5'd23, b_signed: 1'b0};
      S_MUL_H: mreq = '{a: {r32_r[55], r32_r}, b: TURN_INV_2PI,
                        last_bit: 5'd29, b_signed: 1'b0};
      S_MUL_X: mreq = '{a: {{25{cs_r[31]}}, cs_r}, b: trav_r,
                        last_bit: 5'd31, b_signed: 1'b1};
      S_MUL_Y: mreq = '{a: {{25{sn_r[31]}}, sn_r}, b: trav_r,
                        last_bit: 5'd31, b_signed: 1'b1};
      default: mreq = '{a: '0, b: '0, last_bit: 5'd31, b_signed: 1'b0};
    endcase
  end

  ddo_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .go    (mul_go_r),
    .req   (mreq),
    .done  (mul_done),
    .acc   (mul_acc),
    .low   (mul_low)
  );

  ddo_cordic #(
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_cordic (
    .clk     (clk),
    .rst_n   (rst_n),
    .go      (cor_go_r),
    .angle   (mid_r),
    .done    (cor_done),
    .cos_out (cor_cos),
    .sin_out (cor_sin)
  );

  // Travel and wheel difference, and the pose step from the multiplier
  always_comb begin
    lr_sum = {dl_r[47], dl_r} + {dr_r[47], dr_r};
    lr_dif = {dr_r[47], dr_r} - {dl_r[47], dl_r};
    dx     = {mul_acc[29:0], mul_low[31:30]};
    dy     = {mul_acc[29:0], mul_low[31:30]};
  end

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (in_xfer) begin
                 state_nxt = S_LOAD;
               end
      S_LOAD:  state_nxt = seen_r ? S_MUL_L : S_IDLE;
      S_MUL_L: if (mul_done) begin
                 state_nxt = S_MUL_R;
               end
      S_MUL_R: if (mul_done) begin
                 state_nxt = S_SUMS;
               end
      S_SUMS:  state_nxt = S_MUL_D;
      S_MUL_D: if (mul_done) begin
                 state_nxt = S_MUL_H;
               end
      S_MUL_H: if (mul_done) begin
                 state_nxt = S_CORD;
               end
      S_CORD:  if (cor_done) begin
                 state_nxt = S_MUL_X;
               end
      S_MUL_X: if (mul_done) begin
                 state_nxt = S_MUL_Y;
               end
      S_MUL_Y: if (mul_done) begin
                 state_nxt = S_EMIT;
               end
      S_EMIT:  if (out_free) begin
                 state_nxt = S_IDLE;
               end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Control state, odometry state and registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      mul_go_r    <= 1'b0;
      cor_go_r    <= 1'b0;
      out_valid_r <= 1'b0;
      seen_r      <= 1'b0;
      last_l_r    <= '0;
      last_r_r    <= '0;
      pose_x_r    <= '0;
      pose_y_r    <= '0;
      pose_h_r    <= '0;
      mpt_r       <= MPT_RESET;
      itw_r       <= ITW_RESET;
    end else begin
      state_r  <= state_nxt;
      mul_go_r <= ((state_r == S_LOAD) && seen_r) || (state_r == S_SUMS)
                  || (mul_done && (state_r != S_MUL_Y) && (state_r != S_MUL_H))
                  || cor_done;
      cor_go_r <= (state_r == S_MUL_H) && mul_done;

      // Drop the result once the receiver takes it, load when emitted
      if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      if ((state_r == S_EMIT) && out_free) begin
        out_valid_r <= 1'b1;
      end

      if (cfg_wr) begin
        unique case (paddr[2])
          REG_MPT: mpt_r <= pwdata;
          REG_ITW: itw_r <= pwdata[23:0];
          default: mpt_r <= mpt_r;
        endcase
      end

      if (state_r == S_LOAD) begin
        seen_r   <= 1'b1;
        last_l_r <= smp_l_r;
        last_r_r <= smp_r_r;
      end
      if ((state_r == S_MUL_X) && mul_done) begin
        pose_x_r <= pose_x_r + dx;
      end
      if ((state_r == S_MUL_Y) && mul_done) begin
        pose_y_r <= pose_y_r + dy;
        pose_h_r <= pose_h_r + turn_r;
      end
    end
  end

  // Working registers of one sample
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      smp_l_r <= in_data.left_count;
      smp_r_r <= in_data.right_count;
      stamp_r <= in_data.stamp_in;
    end
    if (state_r == S_LOAD) begin
      tick_l_r <= smp_l_r - last_l_r;
      tick_r_r <= smp_r_r - last_r_r;
    end
    if (mul_done) begin
      unique case (state_r)
        S_MUL_L: dl_r <= {mul_acc[31:0], mul_low[31:16]};
        S_MUL_R: dr_r <= {mul_acc[31:0], mul_low[31:16]};
        S_MUL_D: r32_r <= {mul_acc[31:0], mul_low[31:8]};
        S_MUL_H: begin
          turn_r <= mul_acc[33:2];
          mid_r  <= pose_h_r + mul_acc[34:3];
        end
        default: turn_r <= turn_r;
      endcase
    end
    if (state_r == S_SUMS) begin
      trav_r <= sat32(lr_sum >>> 1);
      diff_r <= sat32(lr_dif);
    end
    if (cor_done) begin
      cs_r <= cor_cos;
      sn_r <= cor_sin;
    end
    if ((state_r == S_EMIT) && out_free) begin
      out_data_r.pos_x     <= pose_x_r;
      out_data_r.pos_y     <= pose_y_r;
      out_data_r.heading   <= pose_h_r;
      out_data_r.stamp_out <= stamp_r;
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign pready    = 1'b1;
  assign prdata    = (paddr[2] == REG_ITW) ? {8'd0, itw_r} : mpt_r;

endmodule
`default_nettype wire

// ===== design/ddo_chk.sv =====
// ----------------------------------------------------------------------------
// ddo_chk - port-level checks for the wheel odometry block
// Watches the top level's ports and flags handshake and sequencing slips.
// ----------------------------------------------------------------------------
`default_nettype none
module ddo_chk (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input ddo_pkg::out_item_t out_data,
  input logic               pready
);
  import ddo_pkg::*;

  // Reset leaves no result pending
  a_rst_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result pending after reset");

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // One sample at a time: a transfer closes the input
  a_in_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input open right after a transfer");

  // Register port never waits
  a_pready: assert property (@(posedge clk) disable iff (!rst_n) pready)
    else $error("pready low");

endmodule

bind differential_drive_odometry ddo_chk u_ddo_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data),
  .pready    (pready)
);
`default_nettype wire

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top - self-checking bench for the wheel odometry block
// Streams encoder samples through the block under several register settings,
// predicts most poses with a fixed-point integrator of its own and compares
// each result transfer field by field, under random sender and receiver idling.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module tb_top;
  import ddo_pkg::*;

  localparam int NUM_STEPS = CORDIC_STEPS_DEF;
  localparam int SETTLE_CYCLES = 400;
  localparam int RANDOM_PER_PHASE = 215;
  localparam int NUM_ROWS = 14;

  logic clk = 1'b0;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  in_item_t in_data;
  logic out_valid;
  logic out_ready;
  out_item_t out_data;
  logic psel, penable, pwrite;
  logic [2:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic pready;

  // Register addresses
  localparam logic [2:0] ADDR_MPT = 3'h0;
  localparam logic [2:0] ADDR_ITW = 3'h4;

  // Directed row kinds
  typedef enum logic [1:0] { ROW_PREDICT, ROW_NO_POSE, ROW_POSE } row_kind_t;

  typedef struct {
    logic [31:0] left;
    logic [31:0] right;
    logic [62:0] stamp;
    row_kind_t   kind;
    out_item_t   pose;
  } drive_row_t;

  out_item_t pose_queue[$];
  int err_count = 0;

  // Predictor state
  logic [31:0] mpt_q;
  logic [23:0] itw_q;
  bit          seen_q;
  logic [31:0] last_l, last_r;
  logic [31:0] px_q, py_q, hd_q;

  // Stimulus walk state
  logic [31:0] walk_l, walk_r;
  int burst_left = 0;

  differential_drive_odometry dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #4 clk = ~clk;

  function automatic longint sx32(logic [31:0] u);
    logic signed [31:0] v;
    v = u;
    return longint'(v);
  endfunction

  function automatic longint clip32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // Rotate the gain vector to a binary angle; cos/sin in Q2.30
  task automatic rotate_unit(input logic [31:0] ang, output longint c, output longint s);
    longint a, x, y, z, xs, ys, t;
    bit flip;
    flip = 1'b0;
    a = sx32(ang);
    if (a > 64'sd1073741824 || a < -64'sd1073741824) begin
      a = sx32(ang + 32'h8000_0000);
      flip = 1'b1;
    end
    x = 64'sd652032874;
    y = 0;
    z = a;
    for (int i = 0; i < NUM_STEPS; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      t = longint'({32'b0, ATAN_TBL[i]});
      if (z >= 0) begin
        x = x - ys; y = y + xs; z = z - t;
      end else begin
        x = x + ys; y = y - xs; z = z + t;
      end
    end
    if (flip) begin
      x = -x; y = -y;
    end
    c = x;
    s = y;
  endtask

  // Integrate one sample into the predicted pose
  task automatic odo_advance(input logic [31:0] l, input logic [31:0] r,
                             input logic [62:0] st, output bit has, output out_item_t p);
    longint m, dl, dr, s, d, rr, hi, full, half, cs, sn, dx, dy;
    logic [63:0] lo, prod;
    logic [31:0] mid;
    has = 1'b0;
    p = '0;
    if (!seen_q) begin
      seen_q = 1'b1;
      last_l = l;
      last_r = r;
      return;
    end
    m = longint'({32'b0, mpt_q});
    dl = (sx32(l - last_l) * m) >>> 16;
    dr = (sx32(r - last_r) * m) >>> 16;
    last_l = l;
    last_r = r;
    s = clip32((dl + dr) >>> 1);
    d = clip32(dr - dl);
    rr = d * longint'({40'b0, itw_q});
    hi = rr >>> 32;
    lo = {32'b0, rr[31:0]};
    prod = lo * 64'd683565276;
    full = hi * 64'sd683565276 + longint'(prod >> 32);
    half = full >>> 1;
    mid = hd_q + half[31:0];
    rotate_unit(mid, cs, sn);
    dx = (s * cs) >>> 30;
    dy = (s * sn) >>> 30;
    px_q = px_q + dx[31:0];
    py_q = py_q + dy[31:0];
    hd_q = hd_q + full[31:0];
    has = 1'b1;
    p.pos_x = px_q;
    p.pos_y = py_q;
    p.heading = hd_q;
    p.stamp_out = st;
  endtask

  // Drive one sample and hold it until the transfer; then maybe start a gap
  task automatic send_sample(input logic [31:0] l, input logic [31:0] r,
                             input logic [62:0] st, input bit typed,
                             input bit typed_has, input out_item_t typed_pose);
    bit has;
    out_item_t p;
    in_valid <= 1'b1;
    in_data <= '{left_count: l, right_count: r, stamp_in: st};
    do @(posedge clk); while (!in_ready);
    odo_advance(l, r, st, has, p);
    if (typed) begin
      has = typed_has;
      p = typed_pose;
    end
    if (has) pose_queue = {pose_queue, p};
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(1, 16);
      if ($urandom_range(0, 3) != 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 30)) @(posedge clk);
      end
    end
  endtask

  // Hold off until the block has drained, then let the last sample settle
  task automatic drain_block();
    in_valid <= 1'b0;
    wait (pose_queue.size() == 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [2:0] addr, input logic [31:0] data);
    @(posedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= addr; pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    if (addr == ADDR_MPT) mpt_q = data;
    else if (addr == ADDR_ITW) itw_q = data[23:0];
  endtask

  function automatic logic [62:0] rand_stamp();
    logic [63:0] v;
    v = {$urandom, $urandom};
    return v[62:0];
  endfunction

  function automatic logic [31:0] step_delta();
    int sel;
    sel = $urandom_range(0, 19);
    if (sel == 0) return 32'd0;
    if (sel < 14) return $urandom_range(0, 4000) - 2000;
    if (sel < 18) return $urandom_range(0, 2097152) - 1048576;
    return $urandom;
  endfunction

  // Random sample: mostly a wheel walk, sometimes raw noise counts
  task automatic send_random();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel == 0) begin
      walk_l = $urandom;
      walk_r = $urandom;
    end else if (sel == 1) begin
      walk_l = walk_l + step_delta();
      walk_r = walk_r;
    end else begin
      walk_l = walk_l + step_delta();
      walk_r = (sel == 2) ? walk_l : walk_r + step_delta();
    end
    send_sample(walk_l, walk_r, rand_stamp(), 1'b0, 1'b0, '0);
  endtask

  // Receiver: stretches of full flow, full stall or random stalls
  initial begin
    int mode;
    out_ready <= 1'b0;
    forever begin
      mode = $urandom_range(0, 2);
      repeat ($urandom_range(1, 300)) begin
        @(posedge clk);
        case (mode)
          0: out_ready <= 1'b1;
          1: out_ready <= 1'b0;
          default: out_ready <= $urandom_range(0, 2) != 0;
        endcase
      end
    end
  end

  // Check each result transfer against the oldest predicted pose
  always @(posedge clk) begin
    out_item_t e;
    if (rst_n && out_valid && out_ready) begin
      if (pose_queue.size() == 0) begin
        $display("%0t: unexpected pose x=%h y=%h h=%h st=%h", $time, out_data.pos_x,
                 out_data.pos_y, out_data.heading, out_data.stamp_out);
        err_count++;
      end else begin
        e = pose_queue.pop_front();
        if (out_data.pos_x !== e.pos_x) begin
          $display("%0t: pos_x exp %h got %h", $time, e.pos_x, out_data.pos_x);
          err_count++;
        end
        if (out_data.pos_y !== e.pos_y) begin
          $display("%0t: pos_y exp %h got %h", $time, e.pos_y, out_data.pos_y);
          err_count++;
        end
        if (out_data.heading !== e.heading) begin
          $display("%0t: heading exp %h got %h", $time, e.heading, out_data.heading);
          err_count++;
        end
        if (out_data.stamp_out !== e.stamp_out) begin
          $display("%0t: stamp_out exp %h got %h", $time, e.stamp_out, out_data.stamp_out);
          err_count++;
        end
      end
    end
  end

  // Watchdog
  initial begin
    #40_000_000;
    $display("FAILURE");
    $finish;
  end

  initial begin
    drive_row_t rows[NUM_ROWS];
    logic [31:0] phase_mpt[6];
    logic [31:0] phase_itw[6];
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_data <= '0;
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0; paddr <= '0; pwdata <= '0;
    mpt_q = MPT_RESET;
    itw_q = ITW_RESET;
    seen_q = 1'b0;
    last_l = '0; last_r = '0;
    px_q = '0; py_q = '0; hd_q = '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed rows at the reset register values
    rows = '{
      '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 63'd0, ROW_NO_POSE, '0},
      '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 63'h7FFF_FFFF_FFFF_FFFF, ROW_POSE,
        '{32'sd0, 32'sd0, 32'sd0, 63'h7FFF_FFFF_FFFF_FFFF}},
      '{32'd4799, 32'd4799, 63'd1, ROW_PREDICT, '0},
      '{32'd3799, 32'd5799, 63'h2AAA_AAAA_AAAA_AAAA, ROW_PREDICT, '0},
      '{32'd3799, 32'd5799, 63'h5555_5555_5555_5555, ROW_PREDICT, '0},
      '{32'h7FFF_FFFF, 32'h8000_0000, 63'd2, ROW_PREDICT, '0},
      '{32'h8000_0000, 32'h7FFF_FFFF, 63'd3, ROW_PREDICT, '0},
      '{32'h0000_0000, 32'h0000_0000, 63'd4, ROW_PREDICT, '0},
      '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 63'd5, ROW_PREDICT, '0},
      '{32'h8000_0000, 32'h8000_0000, 63'd6, ROW_PREDICT, '0},
      '{32'h8000_1000, 32'h8000_0000, 63'd7, ROW_PREDICT, '0},
      '{32'h8000_1000, 32'h8000_3000, 63'd8, ROW_PREDICT, '0},
      '{32'h8000_0000, 32'h8000_3000, 63'd9, ROW_PREDICT, '0},
      '{32'h8000_0000, 32'h8000_3000, 63'd10, ROW_PREDICT, '0}
    };
    foreach (rows[i])
      send_sample(rows[i].left, rows[i].right, rows[i].stamp, rows[i].kind != ROW_PREDICT,
                  rows[i].kind == ROW_POSE, rows[i].pose);
    walk_l = 32'h8000_0000;
    walk_r = 32'h8000_3000;

    // Register settings per phase: defaults, minimum, maximum, random, zero, bounded random
    phase_mpt = '{MPT_RESET, 32'd1, 32'hFFFF_FFFF, $urandom, 32'd0, $urandom_range(1, 20000000)};
    phase_itw = '{ITW_RESET, 32'd1, 32'hFF_FFFF, $urandom_range(1, 24'hFF_FFFF), 32'd0,
                  $urandom_range(1, 2000000)};
    for (int ph = 0; ph < 6; ph++) begin
      drain_block();
      cfg_write(ADDR_MPT, phase_mpt[ph]);
      cfg_write(ADDR_ITW, phase_itw[ph]);
      repeat (RANDOM_PER_PHASE) send_random();
    end

    // Wait for the tail, then report
    in_valid <= 1'b0;
    wait (pose_queue.size() == 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (err_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
